// ===== rtl/iir_df2_pkg.sv =====
// Shared types and constants of the direct form II IIR filter.
package iir_df2_pkg;

    // Fixed-point formats
    localparam int X_W   = 16;              // sample, Q15
    localparam int C_W   = 32;              // coefficient, Q8.24
    localparam int W_W   = 48;              // state, Q17.31
    localparam int LO_W  = 24;              // low half of a state word in the split multiply
    localparam int MB_W  = W_W - LO_W + 1;  // multiplier B operand (signed)
    localparam int P_W   = C_W + MB_W;      // product width
    localparam int LR_W  = P_W - LO_W;      // rounded low partial product
    localparam int ACC_W = 60;              // accumulator width

    localparam int A0_SHIFT = 8;
    localparam int A0_RND   = 128;
    localparam int LO_RND   = 1 << (LO_W - 1);
    localparam int Y_SHIFT  = 16;
    localparam int Y_RND    = 1 << (Y_SHIFT - 1);
    localparam int Q15_MAX  = 32767;
    localparam int Q15_MIN  = -32768;

    localparam logic signed [ACC_W-1:0] W_MAX = {{(ACC_W-W_W+1){1'b0}}, {(W_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] W_MIN = ~W_MAX;

    localparam int TAPS_W = 4;
    localparam logic [TAPS_W-1:0] TAPS_RESET = 4'd9;

    typedef enum logic {
        OP_FILTER = 1'b0,
        OP_COEF   = 1'b1
    } op_t;

    typedef enum logic {
        BANK_FB = 1'b0,
        BANK_FF = 1'b1
    } bank_t;

    typedef enum logic {
        CFG_FEEDBACK_TAPS    = 1'b0,
        CFG_FEEDFORWARD_TAPS = 1'b1
    } cfg_index_t;

    typedef struct packed {
        op_t                     op;
        bank_t                   coef_bank;
        logic [3:0]              coef_index;
        logic signed [C_W-1:0]   coef_value;
        logic signed [X_W-1:0]   sample;
    } item_t;

    typedef struct packed {
        logic signed [X_W-1:0]   filtered;
        logic                    saturated;
    } result_t;

    typedef struct packed {
        cfg_index_t              index;
        logic [TAPS_W-1:0]       value;
    } cfg_t;

    typedef enum logic [1:0] {
        PART_NONE,
        PART_A0,
        PART_LO,
        PART_HI
    } part_t;

    typedef struct packed {
        part_t  part;       // multiply issued this cycle
        bank_t  bank;       // coefficient store to read
        logic   use_w;      // state operand is the new w
        logic   acc_y;      // high product goes to the output sum
        logic   load_x;     // capture sample
        logic   coef_we;    // write coefficient from the item
        logic   latch_w;    // saturate and hold w
        logic   finalize;   // round output, shift delay line
    } cmd_t;

    typedef struct packed {
        logic   out_stall;  // result register full and not taken
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_A0,
        ST_FB_LO,
        ST_FB_HI,
        ST_FF_LO,
        ST_FF_HI,
        ST_DRAIN_W,
        ST_LATCH_W,
        ST_B0_LO,
        ST_B0_HI,
        ST_DRAIN_Y,
        ST_FINAL
    } state_t;

endpackage

// ===== rtl/iir_df2_stream_if.sv =====
// Valid/ready channel carrying one payload per transfer.
interface iir_df2_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/iir_direct_form_two_filter.sv =====
// Direct form II IIR filter, fixed point, one shared multiplier.
//
// Channels: item (sink) carries either a sample to filter (op = filter) or one
// coefficient write (op = coef) into the a or b store; result (source) carries
// one saturated Q15 output per sample item; cfg (sink) writes the feedback and
// feedforward tap counts and is always ready.
// Throughput: a coefficient item gives no result and leaves the block ready for
// the next item. A sample item holds ready low from its transfer until its
// result is written, longer with more taps (the b0 passes are skipped when nff
// is zero); the result appears in the same cycle that ready returns. The work
// per sample is set by the single 32x25 multiplier, which takes two passes per
// state tap (low and high half of the 48-bit state word).
// Reset: delay line and coefficients clear to zero, both tap counts to nine.
// Stall: a finished result waits in the output register; the next item is
// accepted meanwhile, and its computation holds in its last cycle until the
// previous result has been transferred.
module iir_direct_form_two_filter
    import iir_df2_pkg::*;
#(
    parameter int MAX_ORDER = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    iir_df2_stream_if.sink    item,
    iir_df2_stream_if.source  result,
    iir_df2_stream_if.sink    cfg
);
    localparam int TAP_W = $clog2(MAX_ORDER + 1);

    cmd_t             cmd;
    status_t          status;
    logic [TAP_W-1:0] tap;
    item_t            item_data;
    cfg_t             cfg_data;
    result_t          result_data;

    assign item_data   = item.data;
    assign cfg_data    = cfg.data;
    assign result.data = result_data;

    iir_df2_ctrl #(
        .MAX_ORDER (MAX_ORDER)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_op    (item_data.op),
        .item_ready (item.ready),
        .cfg_valid  (cfg.valid),
        .cfg_data   (cfg_data),
        .cfg_ready  (cfg.ready),
        .status     (status),
        .cmd        (cmd),
        .tap        (tap)
    );

    iir_df2_datapath #(
        .MAX_ORDER (MAX_ORDER)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .tap          (tap),
        .item_data    (item_data),
        .result_ready (result.ready),
        .result_valid (result.valid),
        .result_data  (result_data),
        .status       (status)
    );

endmodule

// ===== rtl/iir_df2_ctrl.sv =====
// Sequencer of the filter: tap counters, configuration registers, command generation.
module iir_df2_ctrl
    import iir_df2_pkg::*;
#(
    parameter int MAX_ORDER = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  op_t                  item_op,
    output logic                 item_ready,
    input  logic                 cfg_valid,
    input  cfg_t                 cfg_data,
    output logic                 cfg_ready,
    input  status_t              status,
    output cmd_t                 cmd,
    output logic [$clog2(MAX_ORDER+1)-1:0] tap
);
    localparam int NCOEF = MAX_ORDER + 1;
    localparam int TAP_W = $clog2(NCOEF);
    localparam int CNT_W = $clog2(NCOEF + 1);

    state_t            state_reg, state_next;
    logic [TAP_W-1:0]  tap_reg, tap_next;
    logic [TAPS_W-1:0] fb_taps_reg, ff_taps_reg;
    logic [CNT_W-1:0]  nfb, nff, tap_inc;
    logic              item_acc;

    assign cfg_ready = 1'b1;
    assign item_ready = (state_reg == ST_IDLE);
    assign item_acc = item_valid && item_ready;
    assign tap = tap_reg;
    assign tap_inc = CNT_W'(tap_reg) + 1'b1;

    // effective tap counts; feedback never drops below a0
    always_comb
    begin
        if (int'(fb_taps_reg) > NCOEF)
            nfb = CNT_W'(NCOEF);
        else if (fb_taps_reg == '0)
            nfb = CNT_W'(1);
        else
            nfb = CNT_W'(fb_taps_reg);
        if (int'(ff_taps_reg) > NCOEF)
            nff = CNT_W'(NCOEF);
        else
            nff = CNT_W'(ff_taps_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_taps_reg <= TAPS_RESET;
            ff_taps_reg <= TAPS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_data.index)
                CFG_FEEDBACK_TAPS:    fb_taps_reg <= cfg_data.value;
                CFG_FEEDFORWARD_TAPS: ff_taps_reg <= cfg_data.value;
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tap_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        tap_next   = tap_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                tap_next = '0;
                if (item_acc && item_op == OP_FILTER)
                    state_next = ST_A0;
            end
            ST_A0:
            begin
                tap_next = TAP_W'(1);
                if (nfb > CNT_W'(1))
                    state_next = ST_FB_LO;
                else if (nff > CNT_W'(1))
                    state_next = ST_FF_LO;
                else
                    state_next = ST_DRAIN_W;
            end
            ST_FB_LO:
                state_next = ST_FB_HI;
            ST_FB_HI:
            begin
                if (tap_inc < nfb)
                begin
                    tap_next   = TAP_W'(tap_inc);
                    state_next = ST_FB_LO;
                end
                else if (nff > CNT_W'(1))
                begin
                    tap_next   = TAP_W'(1);
                    state_next = ST_FF_LO;
                end
                else
                    state_next = ST_DRAIN_W;
            end
            ST_FF_LO:
                state_next = ST_FF_HI;
            ST_FF_HI:
            begin
                if (tap_inc < nff)
                begin
                    tap_next   = TAP_W'(tap_inc);
                    state_next = ST_FF_LO;
                end
                else
                    state_next = ST_DRAIN_W;
            end
            ST_DRAIN_W:
                state_next = ST_LATCH_W;
            ST_LATCH_W:
            begin
                tap_next = '0;
                if (nff != '0)
                    state_next = ST_B0_LO;
                else
                    state_next = ST_FINAL;
            end
            ST_B0_LO:
                state_next = ST_B0_HI;
            ST_B0_HI:
                state_next = ST_DRAIN_Y;
            ST_DRAIN_Y:
                state_next = ST_FINAL;
            ST_FINAL:
                if (!status.out_stall)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd = '{part: PART_NONE, bank: BANK_FB, default: 1'b0};
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load_x  = item_acc && item_op == OP_FILTER;
                cmd.coef_we = item_acc && item_op == OP_COEF;
            end
            ST_A0:
                cmd.part = PART_A0;
            ST_FB_LO:
                cmd.part = PART_LO;
            ST_FB_HI:
                cmd.part = PART_HI;
            ST_FF_LO:
            begin
                cmd.part = PART_LO;
                cmd.bank = BANK_FF;
            end
            ST_FF_HI:
            begin
                cmd.part  = PART_HI;
                cmd.bank  = BANK_FF;
                cmd.acc_y = 1'b1;
            end
            ST_LATCH_W:
                cmd.latch_w = 1'b1;
            ST_B0_LO:
            begin
                cmd.part  = PART_LO;
                cmd.bank  = BANK_FF;
                cmd.use_w = 1'b1;
            end
            ST_B0_HI:
            begin
                cmd.part  = PART_HI;
                cmd.bank  = BANK_FF;
                cmd.use_w = 1'b1;
                cmd.acc_y = 1'b1;
            end
            ST_FINAL:
                cmd.finalize = !status.out_stall;
            default:
                ;
        endcase
    end

endmodule

// ===== rtl/iir_df2_datapath.sv =====
// Datapath: coefficient stores, delay line, shared multiplier, accumulators, result register.
module iir_df2_datapath
    import iir_df2_pkg::*;
#(
    parameter int MAX_ORDER = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    input  logic [$clog2(MAX_ORDER+1)-1:0] tap,
    input  item_t                item_data,
    input  logic                 result_ready,
    output logic                 result_valid,
    output result_t              result_data,
    output status_t              status
);
    localparam int NCOEF = MAX_ORDER + 1;
    localparam int TAP_W = $clog2(NCOEF);
    localparam int DL_W  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

    typedef struct packed {
        part_t part;
        logic  acc_y;
    } tag_t;

    logic signed [C_W-1:0]   fb_coef_reg [NCOEF];
    logic signed [C_W-1:0]   ff_coef_reg [NCOEF];
    logic signed [W_W-1:0]   dl_reg [MAX_ORDER];
    logic signed [X_W-1:0]   x_reg;
    logic signed [W_W-1:0]   w_reg, w_next;
    logic                    sat_reg, w_clip;
    logic signed [P_W-1:0]   prod, prod_reg;
    tag_t                    tag_reg;
    logic signed [LR_W-1:0]  lo_rnd_reg;
    logic signed [ACC_W-1:0] acc_w_reg, acc_y_reg, term, r_full;
    logic signed [C_W-1:0]   coef_a;
    logic signed [W_W-1:0]   sv;
    logic signed [MB_W-1:0]  op_b;
    logic [TAP_W-1:0]        dl_idx;
    logic signed [X_W-1:0]   r_sat;
    logic                    r_clip;
    logic                    out_valid_reg;
    result_t                 res_reg;

    assign dl_idx = tap - 1'b1;

    // operand selection and the one shared multiplier
    always_comb
    begin
        coef_a = (cmd.bank == BANK_FF) ? ff_coef_reg[tap] : fb_coef_reg[tap];
        sv = '0;
        if (cmd.use_w)
            sv = w_reg;
        else if (int'(dl_idx) < MAX_ORDER)
            sv = dl_reg[dl_idx[DL_W-1:0]];
        case (cmd.part)
            PART_A0: op_b = MB_W'(x_reg);
            PART_LO: op_b = {1'b0, sv[LO_W-1:0]};
            PART_HI: op_b = MB_W'($signed(sv[W_W-1:LO_W]));
            default: op_b = '0;
        endcase
    end

    assign prod = coef_a * op_b;
    assign term = ACC_W'(prod_reg) + ACC_W'(lo_rnd_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tag_reg <= '{part: PART_NONE, acc_y: 1'b0};
        else
            tag_reg <= '{part: cmd.part, acc_y: cmd.acc_y};
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod;
    end

    // accumulate stage; a tap's value is c*hi + round(c*lo / 2^24)
    always_ff @(posedge clk)
    begin
        case (tag_reg.part)
            PART_A0:
            begin
                acc_w_reg <= ACC_W'((prod_reg + P_W'(A0_RND)) >>> A0_SHIFT);
                acc_y_reg <= '0;
            end
            PART_LO:
                lo_rnd_reg <= LR_W'((prod_reg + P_W'(LO_RND)) >>> LO_W);
            PART_HI:
            begin
                if (tag_reg.acc_y)
                    acc_y_reg <= acc_y_reg + term;
                else
                    acc_w_reg <= acc_w_reg - term;
            end
            default:
                ;
        endcase
    end

    always_comb
    begin
        w_clip = 1'b1;
        if (acc_w_reg > W_MAX)
            w_next = W_MAX[W_W-1:0];
        else if (acc_w_reg < W_MIN)
            w_next = W_MIN[W_W-1:0];
        else
        begin
            w_next = acc_w_reg[W_W-1:0];
            w_clip = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_x)
            x_reg <= item_data.sample;
        if (cmd.latch_w)
        begin
            w_reg   <= w_next;
            sat_reg <= w_clip;
        end
    end

    always_comb
    begin
        r_full = (acc_y_reg + ACC_W'(Y_RND)) >>> Y_SHIFT;
        r_clip = 1'b1;
        if (r_full > ACC_W'(Q15_MAX))
            r_sat = X_W'(Q15_MAX);
        else if (r_full < ACC_W'(Q15_MIN))
            r_sat = X_W'(Q15_MIN);
        else
        begin
            r_sat  = r_full[X_W-1:0];
            r_clip = 1'b0;
        end
    end

    // coefficient stores and delay line reset to zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NCOEF; i++)
            begin
                fb_coef_reg[i] <= '0;
                ff_coef_reg[i] <= '0;
            end
            for (int i = 0; i < MAX_ORDER; i++)
                dl_reg[i] <= '0;
        end
        else
        begin
            if (cmd.coef_we && int'(item_data.coef_index) <= MAX_ORDER)
            begin
                if (item_data.coef_bank == BANK_FF)
                    ff_coef_reg[TAP_W'(item_data.coef_index)] <= item_data.coef_value;
                else
                    fb_coef_reg[TAP_W'(item_data.coef_index)] <= item_data.coef_value;
            end
            if (cmd.finalize)
            begin
                dl_reg[0] <= w_reg;
                for (int i = 1; i < MAX_ORDER; i++)
                    dl_reg[i] <= dl_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finalize)
            out_valid_reg <= 1'b1;
        else if (result_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finalize)
            res_reg <= '{filtered: r_sat, saturated: sat_reg | r_clip};
    end

    assign result_valid     = out_valid_reg;
    assign result_data      = res_reg;
    assign status.out_stall = out_valid_reg && !result_ready;

endmodule

// ===== rtl/iir_df2_checker.sv =====
// Port-level checker of the filter and its bind to the top level.
module iir_df2_checker
    import iir_df2_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  logic                  item_ready,
    input  op_t                   item_op,
    input  logic                  result_valid,
    input  logic                  result_ready,
    input  logic signed [X_W-1:0] result_filtered,
    input  logic                  result_saturated
);
    logic item_xfer;

    assign item_xfer = item_valid && item_ready;

    // a pending result holds until transferred
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped before transfer");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            $stable(result_filtered) && $stable(result_saturated))
        else $error("stalled result changed");

    // a sample occupies the block; no second item the next cycle
    a_busy_after_sample: assert property (@(posedge clk) disable iff (!rst_n)
        item_xfer && item_op == OP_FILTER |=> !item_ready)
        else $error("item accepted while a sample is in work");

    // coefficient writes never produce a result
    a_coef_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_xfer && item_op == OP_COEF |=> !$rose(result_valid))
        else $error("result after coefficient write");

    // a sample's result cannot appear until the multiply sequence has run
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        item_xfer && item_op == OP_FILTER |=> !$rose(result_valid) ##1 !$rose(result_valid))
        else $error("result too early after sample transfer");

endmodule

bind iir_direct_form_two_filter iir_df2_checker u_iir_df2_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_valid       (item.valid),
    .item_ready       (item.ready),
    .item_op          (item.data.op),
    .result_valid     (result.valid),
    .result_ready     (result.ready),
    .result_filtered  (result.data.filtered),
    .result_saturated (result.data.saturated)
);

// ===== tb/iir_df2_checker.sv =====
// Checker for the IIR filter: tracks coefficients and delay line, predicts and compares outputs.
`timescale 1ns / 100ps

module iir_df2_scoreboard
    import iir_df2_pkg::*;
#(
    parameter int MAX_ORDER = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_ready,
    input  item_t       item_data,
    input  logic        result_valid,
    input  logic        result_ready,
    input  result_t     result_data,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  cfg_t        cfg_data,
    output int unsigned fail_count,
    output int unsigned pending
);

    localparam int NCOEF = MAX_ORDER + 1;
    localparam longint STATE_MAX = (64'sd1 <<< 47) - 64'sd1;
    localparam longint STATE_MIN = -STATE_MAX - 64'sd1;

    logic signed [W_W-1:0]  w_history [MAX_ORDER];
    logic signed [C_W-1:0]  a_coef [NCOEF];
    logic signed [C_W-1:0]  b_coef [NCOEF];
    logic [TAPS_W-1:0]      fb_taps;
    logic [TAPS_W-1:0]      ff_taps;
    result_t                pending_outputs [$];
    result_t                want;
    int unsigned            errors = 0;

    task automatic report(input string what);
        $display("%0t iir_df2_scoreboard: %s", $time, what);
        errors++;
    endtask

    // c * w / 2^24, rounded half up
    function automatic longint scale_q24(input logic signed [C_W-1:0] c,
                                         input logic signed [W_W-1:0] w);
        logic signed [79:0] p;
        p = c * w;
        p = p + 80'sd8388608;
        return longint'(p >>> 24);
    endfunction

    function automatic result_t filter_sample(input logic signed [X_W-1:0] x);
        int unsigned        nfb;
        int unsigned        nff;
        longint             acc;
        longint             y;
        longint             r;
        logic signed [W_W-1:0] w;
        logic               sat;
        result_t            res;
        nfb = (fb_taps > NCOEF) ? NCOEF : fb_taps;
        nff = (ff_taps > NCOEF) ? NCOEF : ff_taps;
        sat = 1'b0;
        acc = (longint'(a_coef[0]) * longint'(x) + 128) >>> 8;
        for (int k = 1; k < nfb; k++)
            acc -= scale_q24(a_coef[k], w_history[k-1]);
        if (acc > STATE_MAX) begin
            acc = STATE_MAX;
            sat = 1'b1;
        end
        if (acc < STATE_MIN) begin
            acc = STATE_MIN;
            sat = 1'b1;
        end
        w = acc[W_W-1:0];
        y = 0;
        for (int k = 0; k < nff; k++)
            y += scale_q24(b_coef[k], (k == 0) ? w : w_history[k-1]);
        r = (y + 32768) >>> 16;
        if (r > Q15_MAX) begin
            r = Q15_MAX;
            sat = 1'b1;
        end
        if (r < Q15_MIN) begin
            r = Q15_MIN;
            sat = 1'b1;
        end
        for (int k = MAX_ORDER - 1; k > 0; k--)
            w_history[k] = w_history[k-1];
        w_history[0] = w;
        res.filtered  = r[X_W-1:0];
        res.saturated = sat;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int k = 0; k < MAX_ORDER; k++)
                w_history[k] = '0;
            for (int k = 0; k < NCOEF; k++) begin
                a_coef[k] = '0;
                b_coef[k] = '0;
            end
            fb_taps = TAPS_RESET;
            ff_taps = TAPS_RESET;
            pending_outputs.delete();
            fail_count <= errors;
            pending    <= 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_data.index == CFG_FEEDBACK_TAPS)
                    fb_taps = cfg_data.value;
                else
                    ff_taps = cfg_data.value;
            end
            // compare before queueing: a result never belongs to the item of the same edge
            if (result_valid && result_ready) begin
                if (pending_outputs.size() == 0) begin
                    report($sformatf("unexpected output %0d sat %0b",
                                     result_data.filtered, result_data.saturated));
                end
                else begin
                    want = pending_outputs.pop_front();
                    if (result_data.filtered !== want.filtered)
                        report($sformatf("filtered got %0d want %0d",
                                         result_data.filtered, want.filtered));
                    if (result_data.saturated !== want.saturated)
                        report($sformatf("saturated got %0b want %0b",
                                         result_data.saturated, want.saturated));
                end
            end
            if (item_valid && item_ready) begin
                if (item_data.op == OP_COEF) begin
                    if (item_data.coef_index <= MAX_ORDER) begin
                        if (item_data.coef_bank == BANK_FF)
                            b_coef[item_data.coef_index] = item_data.coef_value;
                        else
                            a_coef[item_data.coef_index] = item_data.coef_value;
                    end
                end
                else begin
                    pending_outputs.insert(pending_outputs.size(),
                                           filter_sample(item_data.sample));
                end
            end
            fail_count <= errors;
            pending    <= pending_outputs.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// Top of the IIR filter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
    import iir_df2_pkg::*;

    localparam int ITEM_COUNT   = 1100;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 500000;

    logic        clk = 1'b0;
    logic        rst_n;
    int unsigned fail_count;
    int unsigned pending;
    int          idle_pct = 11;
    int          items_sent = 0;
    int unsigned cycles = 0;

    iir_df2_stream_if #(.payload_t(item_t))   item_ch ();
    iir_df2_stream_if #(.payload_t(result_t)) result_ch ();
    iir_df2_stream_if #(.payload_t(cfg_t))    cfg_ch ();

    iir_direct_form_two_filter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    iir_df2_scoreboard chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_ch.valid),
        .item_ready   (item_ch.ready),
        .item_data    (item_ch.data),
        .result_valid (result_ch.valid),
        .result_ready (result_ch.ready),
        .result_data  (result_ch.data),
        .cfg_valid    (cfg_ch.valid),
        .cfg_ready    (cfg_ch.ready),
        .cfg_data     (cfg_ch.data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always #1 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    always @(posedge clk)
        result_ch.ready <= ($urandom_range(99) >= idle_pct);

    function automatic item_t random_item();
        item_t it;
        it.op         = op_t'($urandom_range(1));
        it.coef_bank  = bank_t'($urandom_range(1));
        it.coef_index = 4'($urandom_range(15));
        it.coef_value = $urandom;
        it.sample     = 16'($urandom);
        return it;
    endfunction

    function automatic item_t coef_item(input bank_t bank, input logic [3:0] idx,
                                        input logic signed [C_W-1:0] value);
        item_t it;
        it = random_item();
        it.op         = OP_COEF;
        it.coef_bank  = bank;
        it.coef_index = idx;
        it.coef_value = value;
        return it;
    endfunction

    function automatic item_t sample_item(input logic signed [X_W-1:0] x);
        item_t it;
        it = random_item();
        it.op     = OP_FILTER;
        it.sample = x;
        return it;
    endfunction

    function automatic logic signed [X_W-1:0] random_sample();
        case ($urandom_range(9))
            0:       return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            1, 2, 3: return 16'(int'($urandom_range(2048)) - 1024);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [3:0] pick_taps();
        case ($urandom_range(5))
            0:       return 4'd0;
            1:       return 4'd1;
            2:       return 4'd9;
            3:       return 4'd15;
            default: return 4'($urandom_range(15));
        endcase
    endfunction

    task automatic send_item(input item_t it);
        while ($urandom_range(99) < idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= it;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // both tap counts, one transfer each, valid held across the pair
    task automatic write_taps(input logic [3:0] n_fb, input logic [3:0] n_ff);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= '{index: CFG_FEEDBACK_TAPS, value: n_fb};
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.data  <= '{index: CFG_FEEDFORWARD_TAPS, value: n_ff};
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // wait for every output, then let a trailing coefficient write finish
    task automatic settle();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_stable_coefs();
        send_item(coef_item(BANK_FB, 4'd0, 32'($urandom_range(3 << 23, 1 << 23))));
        for (int k = 1; k <= 8; k++)
            send_item(coef_item(BANK_FB, 4'(k), 32'(int'($urandom_range(1 << 22)) - (1 << 21))));
        for (int k = 0; k <= 8; k++)
            send_item(coef_item(BANK_FF, 4'(k), 32'(int'($urandom_range(1 << 25)) - (1 << 24))));
    endtask

    initial begin
        int mode;
        int n_samples;
        int phase;
        item_t it;
        rst_n           = 1'b0;
        item_ch.valid   = 1'b0;
        item_ch.data    = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.data     = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // coefficients still zero after reset
        send_item(sample_item(16'sh7fff));
        // unity pass-through
        send_item(coef_item(BANK_FB, 4'd0, 32'sh0100_0000));
        send_item(coef_item(BANK_FF, 4'd0, 32'sh0100_0000));
        send_item(sample_item(16'sh8000));
        send_item(sample_item(16'sh7fff));
        send_item(sample_item(16'sh0001));
        send_item(sample_item(16'shffff));
        // extreme taps drive state and output into clipping; out-of-range indexes dropped
        send_item(coef_item(BANK_FB, 4'd1, 32'sh8000_0000));
        send_item(coef_item(BANK_FF, 4'd1, 32'sh7fff_ffff));
        send_item(coef_item(BANK_FB, 4'd9, 32'sh1234_5678));
        send_item(coef_item(BANK_FF, 4'd15, 32'shffff_ffff));
        repeat (4) send_item(sample_item(16'sh7fff));
        settle();
        write_taps(4'd0, 4'd0);
        send_item(sample_item(16'sd1234));
        settle();
        write_taps(4'd15, 4'd15);
        send_item(sample_item(-16'sd5));
        settle();
        write_taps(4'd1, 4'd1);
        send_item(sample_item(16'sh4000));

        phase = 0;
        while (items_sent < ITEM_COUNT) begin
            settle();
            idle_pct = (phase == 3) ? 0 : 11;
            write_taps(pick_taps(), pick_taps());
            mode = $urandom_range(9);
            if (mode < 6) begin
                load_stable_coefs();
            end
            else if (mode < 8) begin
                for (int k = 0; k <= 8; k++) begin
                    send_item(coef_item(BANK_FB, 4'(k), $urandom));
                    send_item(coef_item(BANK_FF, 4'(k), $urandom));
                end
            end
            else begin
                repeat (6) send_item(coef_item(bank_t'($urandom_range(1)),
                                               4'($urandom_range(15)), $urandom));
            end
            n_samples = (phase == 3) ? 200 : $urandom_range(100, 40);
            repeat (n_samples) begin
                if ($urandom_range(99) < 3) begin
                    it = random_item();
                    it.op = OP_COEF;
                    send_item(it);
                end
                else begin
                    send_item(sample_item(random_sample()));
                end
            end
            phase++;
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/iir_df2_pkg.sv
rtl/iir_df2_stream_if.sv
rtl/iir_df2_ctrl.sv
rtl/iir_df2_datapath.sv
rtl/iir_direct_form_two_filter.sv
rtl/iir_df2_checker.sv
tb/iir_df2_checker.sv
tb/tb_top.sv
